// ----- sv/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ----- sv/spf_pkg.sv -----
package spf_pkg;

    localparam int TABLE_DEPTH = 96;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);

    localparam logic [15:0] HIT_MAX = 16'hFFFF;

    // configuration register indexes
    localparam logic [1:0] CFG_ENABLE       = 2'd0;
    localparam logic [1:0] CFG_MIN_SIGNAL   = 2'd1;
    localparam logic [1:0] CFG_PROMOTE_HITS = 2'd2;
    localparam logic [1:0] CFG_FEED_INTERVAL = 2'd3;

    localparam logic              RST_ENABLE        = 1'b1;
    localparam logic signed [7:0] RST_MIN_SIGNAL    = -8'sd92;
    localparam logic [15:0]       RST_PROMOTE_HITS  = 16'd3;
    localparam logic [31:0]       RST_FEED_INTERVAL = 32'd30000;

    // search token handed from cell to cell
    typedef struct packed {
        logic              vld;
        logic              hit;
        logic [SLOT_W-1:0] hit_idx;
        logic [15:0]       hit_hits;
        logic [31:0]       hit_promo;
        logic              free_ok;
        logic [SLOT_W-1:0] vacant_idx;
        logic              old_ok;
        logic [SLOT_W-1:0] old_idx;
        logic [31:0]       old_seen;
    } t_scan;

    // entry write broadcast to all cells
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] idx;
        logic [47:0]       addr;
        logic [15:0]       hits;
        logic [31:0]       seen;
        logic [31:0]       promo;
    } t_wr;

endpackage

// ----- sv/sighting_promotion_filter_top.sv -----
// Flow: an accepted sighting is injected into cell 0, walks the registered cell row, moves the
// state to update and yields its result beat through the output register; a filtered sighting
// goes straight to update. An output stall holds the result in update; no new sighting is taken until it is issued.
// Reset (synchronous, active low) empties the table, clears the output valid register
// and restores the configuration reset values.
module sighting_promotion_filter_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [47:0]               i_device_addr,
    input  logic signed [7:0]         i_signal_dbm,
    input  logic [31:0]               i_time_ms,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_accepted,
    output logic                      o_promoted,
    output logic [47:0]               o_promo_addr,
    output logic signed [7:0]         o_promo_signal,
    output logic [spf_pkg::SLOT_W-1:0] o_slot_index,
    output logic [15:0]               o_hit_count,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [31:0]               i_cfg_data
);
    import spf_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0]        r_state;
    logic              r_enable;
    logic signed [7:0] r_min_signal;
    logic [15:0]       r_promote_hits;
    logic [31:0]       r_feed_interval;

    logic [47:0]       r_key;
    logic signed [7:0] r_sig;
    logic [31:0]       r_time;
    logic              r_reject;
    logic              r_inj;
    logic              r_hit;
    logic [SLOT_W-1:0] r_slot;
    logic [15:0]       r_hit_hits;
    logic [31:0]       r_hit_promo;

    t_scan             w_scan [0:TABLE_DEPTH];
    t_wr               w_wr;
    logic              w_in_acc;
    logic              w_drop;
    logic              w_out_free;
    logic              w_fire;
    logic [15:0]       w_hits_old;
    logic [31:0]       w_promo_old;
    logic [15:0]       w_hits_new;
    logic [31:0]       w_elapsed;
    logic              w_promo;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_drop      = !r_enable || (i_signal_dbm < r_min_signal);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable        <= RST_ENABLE;
            r_min_signal    <= RST_MIN_SIGNAL;
            r_promote_hits  <= RST_PROMOTE_HITS;
            r_feed_interval <= RST_FEED_INTERVAL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ENABLE:        r_enable        <= i_cfg_data[0];
                CFG_MIN_SIGNAL:    r_min_signal    <= i_cfg_data[7:0];
                CFG_PROMOTE_HITS:  r_promote_hits  <= i_cfg_data[15:0];
                CFG_FEED_INTERVAL: r_feed_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // fresh token enters cell 0 with nothing found yet
    always_comb begin
        w_scan[0]     = '0;
        w_scan[0].vld = r_inj;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        spf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (SLOT_W'(g)),
            .i_key   (r_key),
            .i_scan  (w_scan[g]),
            .i_wr    (w_wr),
            .o_scan  (w_scan[g+1])
        );
    end

    // a miss starts from zero hits and a last promotion at time zero
    assign w_hits_old  = r_hit ? r_hit_hits : 16'd0;
    assign w_promo_old = r_hit ? r_hit_promo : 32'd0;
    assign w_hits_new  = (w_hits_old == HIT_MAX) ? w_hits_old : w_hits_old + 16'd1;
    assign w_elapsed   = r_time - w_promo_old;
    assign w_promo     = (w_hits_new >= r_promote_hits) && (w_elapsed >= r_feed_interval);
    assign w_out_free  = !o_out_valid || !i_out_stall;
    assign w_fire      = (r_state == ST_UPDATE) && w_out_free;

    always_comb begin
        w_wr.en    = w_fire && !r_reject;
        w_wr.idx   = r_slot;
        w_wr.addr  = r_key;
        w_wr.hits  = w_hits_new;
        w_wr.seen  = r_time;
        w_wr.promo = w_promo ? r_time : w_promo_old;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_inj       <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_inj       <= w_in_acc && !w_drop;
            o_out_valid <= w_fire || (o_out_valid && i_out_stall);
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= w_drop ? ST_UPDATE : ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    if (w_scan[TABLE_DEPTH].vld) begin
                        r_state <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_key    <= i_device_addr;
            r_sig    <= i_signal_dbm;
            r_time   <= i_time_ms;
            r_reject <= w_drop;
        end
        if (w_scan[TABLE_DEPTH].vld) begin
            r_hit       <= w_scan[TABLE_DEPTH].hit;
            r_hit_hits  <= w_scan[TABLE_DEPTH].hit_hits;
            r_hit_promo <= w_scan[TABLE_DEPTH].hit_promo;
            if (w_scan[TABLE_DEPTH].hit) begin
                r_slot <= w_scan[TABLE_DEPTH].hit_idx;
            end else if (w_scan[TABLE_DEPTH].free_ok) begin
                r_slot <= w_scan[TABLE_DEPTH].vacant_idx;
            end else begin
                r_slot <= w_scan[TABLE_DEPTH].old_idx;
            end
        end
        if (w_fire) begin
            if (r_reject) begin
                o_accepted     <= 1'b0;
                o_promoted     <= 1'b0;
                o_promo_addr   <= '0;
                o_promo_signal <= '0;
                o_slot_index   <= '0;
                o_hit_count    <= '0;
            end else begin
                o_accepted     <= 1'b1;
                o_promoted     <= w_promo;
                o_promo_addr   <= w_promo ? r_key : 48'd0;
                o_promo_signal <= w_promo ? r_sig : 8'sd0;
                o_slot_index   <= r_slot;
                o_hit_count    <= w_hits_new;
            end
        end
    end

`include "assert_macros.svh"

    `ASSERT_IMPLY(a_token_in_search, i_clk, i_rst_n, w_scan[TABLE_DEPTH].vld, r_state == ST_SEARCH)
    `ASSERT_NEXT(a_write_makes_beat, i_clk, i_rst_n, w_wr.en, o_out_valid && o_accepted)
    `ASSERT_IMPLY(a_promo_needs_accept, i_clk, i_rst_n, o_out_valid && o_promoted, o_accepted)
    `ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, w_in_acc, r_state != ST_IDLE)

endmodule

// ----- sv/spf_cell.sv -----
module spf_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [spf_pkg::SLOT_W-1:0] i_idx,
    input  logic [47:0]               i_key,
    input  spf_pkg::t_scan            i_scan,
    input  spf_pkg::t_wr              i_wr,
    output spf_pkg::t_scan            o_scan
);
    import spf_pkg::*;

    logic        r_valid;
    logic [47:0] r_addr;
    logic [15:0] r_hits;
    logic [31:0] r_seen;
    logic [31:0] r_promo;
    t_scan       r_scan;
    t_scan       n_scan;
    logic        w_sel;

    assign w_sel = i_wr.en && (i_wr.idx == i_idx);

    always_comb begin
        n_scan = i_scan;
        if (i_scan.vld) begin
            if (r_valid) begin
                if (!i_scan.hit && (r_addr == i_key)) begin
                    n_scan.hit       = 1'b1;
                    n_scan.hit_idx   = i_idx;
                    n_scan.hit_hits  = r_hits;
                    n_scan.hit_promo = r_promo;
                end
                // strict less-than keeps the lowest index on ties
                if (!i_scan.old_ok || (r_seen < i_scan.old_seen)) begin
                    n_scan.old_ok   = 1'b1;
                    n_scan.old_idx  = i_idx;
                    n_scan.old_seen = r_seen;
                end
            end else if (!i_scan.free_ok) begin
                n_scan.free_ok    = 1'b1;
                n_scan.vacant_idx = i_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_scan.vld <= 1'b0;
        end else begin
            r_scan <= n_scan;
            if (w_sel) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel) begin
            r_addr  <= i_wr.addr;
            r_hits  <= i_wr.hits;
            r_seen  <= i_wr.seen;
            r_promo <= i_wr.promo;
        end
    end

    assign o_scan = r_scan;

endmodule
